// ===== rtl/prscnt_pkg.sv =====
// shared widths, constants and types for the prefix residue subarray counter
// no dependencies

package prscnt_pkg;

    localparam int VALUE_W         = 20;
    localparam int MOD_CFG_W       = 17;
    localparam int PAIR_W          = 25;
    localparam int SEG_W           = 17;
    localparam int SEQ_TAG_W       = 8;
    localparam int EPOCH_W         = 16;
    localparam int DEF_MAX_MODULUS = 65536;

    localparam logic [PAIR_W-1:0] PAIR_PRIME = 25'd20091101;
    localparam logic [SEG_W-1:0]  SEG_MAX    = '1;

    typedef struct packed {
        logic [SEQ_TAG_W-1:0] tag;
        logic [PAIR_W-1:0]    cnt;
    } t_hist_entry;

endpackage

// ===== rtl/prscnt_ram.sv =====
// generic single-clock ram, one write port and one registered read port
// no dependencies

module prscnt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/prscnt_mod_unit.sv =====
// bit-serial restoring remainder unit, one dividend bit per cycle
// no dependencies

module prscnt_mod_unit #(
    parameter int DVD_W = 21,
    parameter int DIV_W = 17
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [DVD_W-1:0] i_dividend,
    input  logic [DIV_W-1:0] i_divisor,
    output logic             o_done,
    output logic [DIV_W-1:0] o_rem
);

    localparam int CNT_W = (DVD_W > 1) ? $clog2(DVD_W) : 1;

    logic             r_busy;
    logic             r_done;
    logic [CNT_W-1:0] r_cnt;
    logic [DVD_W-1:0] r_dvd;
    logic [DIV_W-1:0] r_div;
    logic [DIV_W-1:0] r_rem;

    logic [DIV_W:0]   w_shift;
    logic [DIV_W:0]   w_sub;
    logic             w_ge;

    assign w_shift = {r_rem, r_dvd[DVD_W-1]};
    assign w_ge    = w_shift >= {1'b0, r_div};
    assign w_sub   = w_shift - {1'b0, r_div};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DVD_W - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_dvd <= i_dividend;
            r_div <= i_divisor;
            r_rem <= '0;
        end else if (r_busy) begin
            r_dvd <= {r_dvd[DVD_W-2:0], 1'b0};
            r_rem <= w_ge ? w_sub[DIV_W-1:0] : w_shift[DIV_W-1:0];
        end
    end

    assign o_done = r_done;
    assign o_rem  = r_rem;

endmodule

// ===== rtl/prefix_residue_subarray_counter_top.sv =====
// Each item passes the issue, divide, read, read-modify-write and output states; the divide
// runs one bit per cycle over D bits, D being the width of prefix residue plus value (21 at
// the default MAX_MODULUS), and an item with the start flag first passes a begin state.
// Histogram and seen residues live in two memories of MAX_MODULUS entries, read once and
// written back once per item. After reset a clearing pass runs before the first item is
// taken; it runs again when the 8-bit sequence tag or the 16-bit segment epoch wraps.
// top level; depends on prscnt_pkg, prscnt_ram and prscnt_mod_unit

module prefix_residue_subarray_counter_top import prscnt_pkg::*; #(
    parameter int MAX_MODULUS = DEF_MAX_MODULUS
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [MOD_CFG_W-1:0] i_cfg_data,       // modulus
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [23:0]          i_s_axis_tdata,   // value, zero pad
    input  logic [0:0]           i_s_axis_tuser,   // start_of_sequence
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [47:0]          o_m_axis_tdata    // pair_count, segment_count, zero pad
);

    localparam int RES_W = (MAX_MODULUS > 1) ? $clog2(MAX_MODULUS) : 1;
    localparam int K_W   = $clog2(MAX_MODULUS + 1);
    localparam int D_W   = ((RES_W > VALUE_W) ? RES_W : VALUE_W) + 1;
    localparam int CMP_W = (K_W > MOD_CFG_W) ? K_W : MOD_CFG_W;
    localparam int HIST_W = $bits(t_hist_entry);

    typedef enum logic [8:0] {
        S_IDLE  = 9'b000000001,
        S_BEGIN = 9'b000000010,
        S_SWEEP = 9'b000000100,
        S_ISSUE = 9'b000001000,
        S_DIV   = 9'b000010000,
        S_RD    = 9'b000100000,
        S_RMW   = 9'b001000000,
        S_EPOCH = 9'b010000000,
        S_OUT   = 9'b100000000
    } t_state;

    t_state               r_state, n_state;
    logic [MOD_CFG_W-1:0] r_cfg_mod;
    logic [VALUE_W-1:0]   r_value;
    logic                 r_start;
    logic                 r_item;
    logic [RES_W-1:0]     r_prefix;
    logic [RES_W-1:0]     r_res;
    logic [PAIR_W-1:0]    r_pair;
    logic [SEG_W-1:0]     r_seg;
    logic [SEQ_TAG_W-1:0] r_seq;
    logic [EPOCH_W-1:0]   r_epoch;
    logic [RES_W-1:0]     r_ptr;
    logic                 r_clr_hist;
    logic                 r_clr_seen;
    logic                 r_ret_epoch;
    logic                 r_out_valid;
    logic [PAIR_W-1:0]    r_out_pair;
    logic [SEG_W-1:0]     r_out_seg;

    logic                 w_in_acc;
    logic [CMP_W-1:0]     w_cfg_ext;
    logic [K_W-1:0]       w_k;
    logic                 w_div_done;
    logic [K_W-1:0]       w_rem;
    t_hist_entry          w_hist_rd;
    t_hist_entry          w_hist_wr;
    logic [HIST_W-1:0]    w_hist_rd_bits;
    logic [EPOCH_W-1:0]   w_seen_rd;
    logic [PAIR_W-1:0]    w_h;
    logic [PAIR_W:0]      w_psum;
    logic [PAIR_W-1:0]    w_pair_new;
    logic [PAIR_W:0]      w_h1;
    logic [PAIR_W-1:0]    w_bin_new;
    logic                 w_hit;
    logic                 w_epoch_max;
    logic                 w_seq_max;
    logic                 w_sweep_end;

    logic                 w_hist_we;
    logic [RES_W-1:0]     w_hist_waddr;
    logic                 w_seen_we;
    logic [RES_W-1:0]     w_seen_waddr;
    logic [EPOCH_W-1:0]   w_seen_wdata;

    assign o_cfg_ready     = 1'b1;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;

    // effective modulus: zero reads as one, large values saturate
    always_comb begin
        w_cfg_ext = CMP_W'(r_cfg_mod);
        if (w_cfg_ext == '0) begin
            w_k = K_W'(1);
        end else if (w_cfg_ext > CMP_W'(MAX_MODULUS)) begin
            w_k = K_W'(MAX_MODULUS);
        end else begin
            w_k = w_cfg_ext[K_W-1:0];
        end
    end

    prscnt_mod_unit #(
        .DVD_W (D_W),
        .DIV_W (K_W)
    ) u_mod (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (r_state == S_ISSUE),
        .i_dividend (D_W'(r_prefix) + D_W'(r_value)),
        .i_divisor  (w_k),
        .o_done     (w_div_done),
        .o_rem      (w_rem)
    );

    assign w_hist_rd   = t_hist_entry'(w_hist_rd_bits);
    assign w_h         = (w_hist_rd.tag == r_seq) ? w_hist_rd.cnt :
                         ((r_res == '0) ? PAIR_W'(1) : '0);
    assign w_psum      = {1'b0, r_pair} + {1'b0, w_h};
    assign w_pair_new  = (w_psum >= {1'b0, PAIR_PRIME}) ?
                         PAIR_W'(w_psum - {1'b0, PAIR_PRIME}) : w_psum[PAIR_W-1:0];
    assign w_h1        = {1'b0, w_h} + 1'b1;
    assign w_bin_new   = (w_h1 == {1'b0, PAIR_PRIME}) ? '0 : w_h1[PAIR_W-1:0];
    assign w_hit       = (w_seen_rd == r_epoch);
    assign w_epoch_max = (r_epoch == '1);
    assign w_seq_max   = (r_seq == '1);
    assign w_sweep_end = (r_ptr == RES_W'(MAX_MODULUS - 1));

    always_comb begin
        w_hist_we     = 1'b0;
        w_hist_waddr  = r_res;
        w_hist_wr.tag = r_seq;
        w_hist_wr.cnt = w_bin_new;
        w_seen_we     = 1'b0;
        w_seen_waddr  = r_res;
        w_seen_wdata  = r_epoch;
        unique case (r_state)
            S_SWEEP: begin
                w_hist_we    = r_clr_hist;
                w_hist_waddr = r_ptr;
                w_hist_wr    = '0;
                w_seen_we    = r_clr_seen;
                w_seen_waddr = r_ptr;
                w_seen_wdata = '0;
            end
            S_BEGIN: begin
                w_seen_we    = !(w_seq_max || w_epoch_max);
                w_seen_waddr = '0;
                w_seen_wdata = r_epoch + 1'b1;
            end
            S_RMW: begin
                w_hist_we    = 1'b1;
                w_seen_we    = !(w_hit && w_epoch_max);
                w_seen_wdata = w_hit ? r_epoch + 1'b1 : r_epoch;
            end
            S_EPOCH: begin
                w_seen_we    = 1'b1;
                w_seen_wdata = r_epoch + 1'b1;
            end
            default: begin
            end
        endcase
    end

    prscnt_ram #(
        .WIDTH (HIST_W),
        .DEPTH (MAX_MODULUS)
    ) u_hist_ram (
        .i_clk   (i_clk),
        .i_we    (w_hist_we),
        .i_waddr (w_hist_waddr),
        .i_wdata (w_hist_wr),
        .i_re    (r_state == S_RD),
        .i_raddr (r_res),
        .o_rdata (w_hist_rd_bits)
    );

    prscnt_ram #(
        .WIDTH (EPOCH_W),
        .DEPTH (MAX_MODULUS)
    ) u_seen_ram (
        .i_clk   (i_clk),
        .i_we    (w_seen_we),
        .i_waddr (w_seen_waddr),
        .i_wdata (w_seen_wdata),
        .i_re    (r_state == S_RD),
        .i_raddr (r_res),
        .o_rdata (w_seen_rd)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) begin
                    n_state = i_s_axis_tuser[0] ? S_BEGIN : S_ISSUE;
                end
            end
            S_BEGIN: begin
                if (w_seq_max || w_epoch_max) begin
                    n_state = S_SWEEP;
                end else begin
                    n_state = r_item ? S_ISSUE : S_IDLE;
                end
            end
            S_SWEEP: begin
                if (w_sweep_end) begin
                    n_state = r_ret_epoch ? S_EPOCH : S_BEGIN;
                end
            end
            S_ISSUE: n_state = S_DIV;
            S_DIV: begin
                if (w_div_done) begin
                    n_state = S_RD;
                end
            end
            S_RD:  n_state = S_RMW;
            S_RMW: n_state = (w_hit && w_epoch_max) ? S_SWEEP : S_OUT;
            S_EPOCH: n_state = S_OUT;
            S_OUT: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_BEGIN;
            r_cfg_mod   <= MOD_CFG_W'(1);
            r_item      <= 1'b0;
            r_prefix    <= '0;
            r_pair      <= '0;
            r_seg       <= '0;
            r_seq       <= '1;
            r_epoch     <= '1;
            r_ptr       <= '0;
            r_clr_hist  <= 1'b0;
            r_clr_seen  <= 1'b0;
            r_ret_epoch <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_cfg_mod <= i_cfg_data;
            end
            if ((r_state == S_OUT) && (!r_out_valid || i_m_axis_tready)) begin
                r_out_valid <= 1'b1;
            end else if (o_m_axis_tvalid && i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (w_in_acc) begin
                        r_item <= 1'b1;
                    end
                end
                S_BEGIN: begin
                    if (w_seq_max || w_epoch_max) begin
                        r_clr_hist  <= w_seq_max;
                        r_clr_seen  <= w_epoch_max;
                        r_ret_epoch <= 1'b0;
                        r_ptr       <= '0;
                        if (w_seq_max) begin
                            r_seq <= '0;
                        end
                        if (w_epoch_max) begin
                            r_epoch <= '0;
                        end
                    end else begin
                        r_seq    <= r_seq + 1'b1;
                        r_epoch  <= r_epoch + 1'b1;
                        r_prefix <= '0;
                        r_pair   <= '0;
                        r_seg    <= '0;
                    end
                end
                S_SWEEP: begin
                    r_ptr <= r_ptr + 1'b1;
                end
                S_DIV: begin
                    if (w_div_done) begin
                        r_res    <= w_rem[RES_W-1:0];
                        r_prefix <= w_rem[RES_W-1:0];
                    end
                end
                S_RMW: begin
                    r_pair <= w_pair_new;
                    if (w_hit) begin
                        if (r_seg != SEG_MAX) begin
                            r_seg <= r_seg + 1'b1;
                        end
                        if (w_epoch_max) begin
                            r_epoch     <= '0;
                            r_clr_hist  <= 1'b0;
                            r_clr_seen  <= 1'b1;
                            r_ret_epoch <= 1'b1;
                            r_ptr       <= '0;
                        end else begin
                            r_epoch <= r_epoch + 1'b1;
                        end
                    end
                end
                S_EPOCH: begin
                    r_epoch <= r_epoch + 1'b1;
                end
                default: begin
                end
            endcase
        end
    end

    // item payload and result payload
    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_value <= i_s_axis_tdata[VALUE_W-1:0];
            r_start <= i_s_axis_tuser[0];
        end
        if ((r_state == S_OUT) && (!r_out_valid || i_m_axis_tready)) begin
            r_out_pair <= r_pair;
            r_out_seg  <= r_seg;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {6'd0, r_out_seg, r_out_pair};

    a_accept_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_in_acc |=> ((r_state == S_BEGIN) && r_start) || ((r_state == S_ISSUE) && !r_start))
        else $error("accepted item did not enter begin or issue");

    a_div_done_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == S_DIV))
        else $error("remainder unit finished outside divide state");

    a_pair_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pair < PAIR_PRIME)
        else $error("pair total left its modular range");

    a_sweep_idle_in: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SWEEP) |-> !o_s_axis_tready && !w_hist_we || r_clr_hist)
        else $error("clearing pass overlapped input or stray histogram write");

endmodule
